/* design/sorted_list_merge_macros.svh */
// ----------------------------------------------------------------------------
// sorted_list_merge_macros.svh
// Assertion macros shared by the sorted list merge checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_MERGE_MACROS_SVH
`define SORTED_LIST_MERGE_MACROS_SVH

// property checked on every rising edge outside reset
`define SLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising edge, reset included
`define SLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* design/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg
// Shared widths, defaults and action codes of the sorted list merge.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int VAL_W       = 32;
  localparam int ACT_W       = 2;
  localparam int DEPTH_A_DEF = 32;
  localparam int DEPTH_B_DEF = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_A = 2'd0,
    ACT_PUSH_B = 2'd1,
    ACT_MERGE  = 2'd2
  } action_e;

endpackage

/* design/slm_list.sv */
// ----------------------------------------------------------------------------
// slm_list
// Storage of one list: single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module slm_list #(
  parameter int DEPTH = slm_pkg::DEPTH_A_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [slm_pkg::VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [slm_pkg::VAL_W-1:0] rdata_o
);
  import slm_pkg::*;

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/sorted_list_merge.sv */
// ----------------------------------------------------------------------------
// sorted_list_merge
// Two list memories filled by pushes; a merge emits the combined ascending
// sequence with B ahead of A on equal values.
// ----------------------------------------------------------------------------
//  channel   dir  tdata         tuser       tlast
//  s_axis    in   value[31:0]   action[1:0] -
//  m_axis    out  value_res     source      last
//
//  A push writes one list in idle; action code 3 is taken and ignored.
//  A merge runs a back-to-front decision pass (one memory read and one
//  compare per element), then an emit pass, each word needing one read of
//  the list memory. s_axis_tready is high only between merges; back pressure
//  on m_axis holds the emit pass. Reset empties both lists; memory contents
//  are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_merge #(
  parameter int DEPTH_A = slm_pkg::DEPTH_A_DEF,
  parameter int DEPTH_B = slm_pkg::DEPTH_B_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [slm_pkg::VAL_W-1:0] s_axis_tdata,  // [31:0] value
  input  logic [slm_pkg::ACT_W-1:0] s_axis_tuser,  // [1:0] action
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [slm_pkg::VAL_W-1:0] m_axis_tdata,  // [31:0] value_res
  output logic                      m_axis_tuser,  // [0] source
  output logic                      m_axis_tlast
);
  import slm_pkg::*;

  localparam int AWA = (DEPTH_A > 1) ? $clog2(DEPTH_A) : 1;
  localparam int AWB = (DEPTH_B > 1) ? $clog2(DEPTH_B) : 1;
  localparam int CAW = $clog2(DEPTH_A + 1);
  localparam int CBW = $clog2(DEPTH_B + 1);
  localparam int NT  = DEPTH_A + DEPTH_B;
  localparam int TW  = $clog2(NT + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_BRD  = 3'd1;  // read both tails
  localparam logic [2:0] ST_BCMP = 3'd2;  // decide back slot
  localparam logic [2:0] ST_FRD  = 3'd3;  // read next word to emit
  localparam logic [2:0] ST_FLD  = 3'd4;  // load output register

  logic [2:0]       state_q, state_d;
  logic [CAW-1:0]   cnt_a_q, cnt_a_d;
  logic [CBW-1:0]   cnt_b_q, cnt_b_d;
  logic [CAW-1:0]   fa_q, fa_d;
  logic [CBW-1:0]   fb_q, fb_d;
  logic [TW-1:0]    rem_q, rem_d;
  logic [NT-1:0]    dec_q, dec_d;   // source bits, front slot at bit 0
  logic             out_vld_q, out_vld_d;
  logic [VAL_W-1:0] out_data_q, out_data_d;
  logic             out_src_q, out_src_d;
  logic             out_last_q, out_last_d;

  logic             we_a, we_b;
  logic [AWA-1:0]   raddr_a;
  logic [AWB-1:0]   raddr_b;
  logic [VAL_W-1:0] rdata_a, rdata_b;
  logic signed [VAL_W-1:0] rd_a, rd_b;
  logic [CAW-1:0]   cnt_a_m1;
  logic [CBW-1:0]   cnt_b_m1;
  logic [TW-1:0]    total;
  logic             accept, pick_a;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign cnt_a_m1 = cnt_a_q - 1'b1;
  assign cnt_b_m1 = cnt_b_q - 1'b1;
  assign total    = TW'(cnt_a_q) + TW'(cnt_b_q);
  assign rd_a     = rdata_a;
  assign rd_b     = rdata_b;

  // memories are written only in idle; read data is used only during a merge
  assign raddr_a = (state_q == ST_BRD) ? cnt_a_m1[AWA-1:0] : fa_q[AWA-1:0];
  assign raddr_b = (state_q == ST_BRD) ? cnt_b_m1[AWB-1:0] : fb_q[AWB-1:0];

  slm_list #(.DEPTH(DEPTH_A), .AW(AWA)) u_list_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[AWA-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  slm_list #(.DEPTH(DEPTH_B), .AW(AWB)) u_list_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[AWB-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // back pass: with both lists nonempty the larger tail goes last, A on ties
  always_comb begin
    if ((cnt_a_q != '0) && (cnt_b_q != '0)) begin
      pick_a = (rd_a >= rd_b);
    end else begin
      pick_a = (cnt_a_q != '0);
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_a_d    = cnt_a_q;
    cnt_b_d    = cnt_b_q;
    fa_d       = fa_q;
    fb_d       = fb_q;
    rem_d      = rem_q;
    dec_d      = dec_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_data_d = out_data_q;
    out_src_d  = out_src_q;
    out_last_d = out_last_q;
    we_a       = 1'b0;
    we_b       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(s_axis_tuser))
            ACT_PUSH_A: begin
              if (cnt_a_q != CAW'(DEPTH_A)) begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + 1'b1;
              end
            end
            ACT_PUSH_B: begin
              if (cnt_b_q != CBW'(DEPTH_B)) begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + 1'b1;
              end
            end
            ACT_MERGE: begin
              if (total != '0) begin
                rem_d   = total;
                state_d = ST_BRD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_BRD: begin
        state_d = ST_BCMP;
      end
      ST_BCMP: begin
        dec_d = {dec_q[NT-2:0], !pick_a};
        if (pick_a) begin
          cnt_a_d = cnt_a_m1;
        end else begin
          cnt_b_d = cnt_b_m1;
        end
        if (total == TW'(1)) begin
          fa_d    = '0;
          fb_d    = '0;
          state_d = ST_FRD;
        end else begin
          state_d = ST_BRD;
        end
      end
      ST_FRD: begin
        // read now only if the output register is free by the load cycle
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_FLD;
        end
      end
      ST_FLD: begin
        out_vld_d  = 1'b1;
        out_src_d  = dec_q[0];
        out_data_d = dec_q[0] ? rdata_b : rdata_a;
        out_last_d = (rem_q == TW'(1));
        dec_d      = dec_q >> 1;
        if (dec_q[0]) begin
          fb_d = fb_q + 1'b1;
        end else begin
          fa_d = fa_q + 1'b1;
        end
        rem_d   = rem_q - 1'b1;
        state_d = (rem_q == TW'(1)) ? ST_IDLE : ST_FRD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      fa_q      <= '0;
      fb_q      <= '0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_a_q   <= cnt_a_d;
      cnt_b_q   <= cnt_b_d;
      fa_q      <= fa_d;
      fb_q      <= fb_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q      <= dec_d;
    out_data_q <= out_data_d;
    out_src_q  <= out_src_d;
    out_last_q <= out_last_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_src_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* design/slm_checker.sv */
// ----------------------------------------------------------------------------
// slm_checker
// Port-level checks of the sorted list merge, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_list_merge_macros.svh"

module slm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [slm_pkg::VAL_W-1:0] s_axis_tdata,
  input logic [slm_pkg::ACT_W-1:0] s_axis_tuser,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [slm_pkg::VAL_W-1:0] m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      m_axis_tlast
);
  import slm_pkg::*;

  logic push_acc;

  assign push_acc = s_axis_tvalid && s_axis_tready &&
                    ((s_axis_tuser == ACT_PUSH_A) || (s_axis_tuser == ACT_PUSH_B));

  // a stalled word holds
  `SLM_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output word changed")

  // a push never yields a word
  `SLM_ASSERT(a_push_silent, push_acc && !m_axis_tvalid |=> !m_axis_tvalid, "output word after a push")

  // no input is taken while the merged sequence is unfinished
  `SLM_ASSERT(a_busy_merge, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken mid merge")

  // nothing is shown right after reset
  `SLM_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

  logic unused_data;
  assign unused_data = ^s_axis_tdata;

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
